>>> src/bsp_point_contents_unit_macros.svh
// Assertion macros used by the top level of the BSP point contents unit.
`ifndef BSP_POINT_CONTENTS_UNIT_MACROS_SVH
`define BSP_POINT_CONTENTS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsp_point_contents_unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsp_point_contents_unit: next-cycle check failed");

`endif

>>> src/bspc_pkg.sv
// Package with the types, codes and constants of the BSP point contents unit.
`default_nettype none

package bspc_pkg;

    localparam int BSPC_NODE_COUNT  = 1024;
    localparam int BSPC_PLANE_COUNT = 2048;
    localparam int BSPC_LEAF_COUNT  = 1024;
    localparam int BSPC_MAX_STEPS   = 64;

    // Field widths fixed by the word format.
    localparam int IDX_W   = 11;
    localparam int CHILD_W = 11;
    localparam int NODE_W  = 10;
    localparam int LEAF_W  = 10;
    localparam int VAL_W   = 32;
    localparam int PROD_W  = 2 * VAL_W;
    // Three products plus the shifted distance fit in 66 bits; one spare.
    localparam int ACC_W   = PROD_W + 3;
    localparam int DIST_SHIFT = 16;

    typedef enum logic [1:0] {
        CMD_WR_NODE  = 2'd0,
        CMD_WR_PLANE = 2'd1,
        CMD_WR_LEAF  = 2'd2,
        CMD_QUERY    = 2'd3
    } t_command;

    typedef struct packed {
        logic        [IDX_W-1:0]   plane;
        logic signed [CHILD_W-1:0] front;
        logic signed [CHILD_W-1:0] back;
    } t_node_entry;

    typedef struct packed {
        logic signed [VAL_W-1:0] nx;
        logic signed [VAL_W-1:0] ny;
        logic signed [VAL_W-1:0] nz;
        logic signed [VAL_W-1:0] offset;
    } t_plane_entry;

    typedef struct packed {
        logic done;
        logic front;
    } t_dot_status;

endpackage

`default_nettype wire

>>> src/bspc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module bspc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/bspc_dot_unit.sv
// Shared multiply-accumulate unit that forms the sign of dot(normal, point) - dist.
`default_nettype none

module bspc_dot_unit
    import bspc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire t_plane_entry            i_plane,
    input  wire logic signed [VAL_W-1:0] i_px,
    input  wire logic signed [VAL_W-1:0] i_py,
    input  wire logic signed [VAL_W-1:0] i_pz,
    output t_dot_status                  o_status
);

    localparam logic [1:0] K_X    = 2'd0;
    localparam logic [1:0] K_Y    = 2'd1;
    localparam logic [1:0] K_Z    = 2'd2;
    localparam logic [1:0] K_LAST = 2'd3;

    logic                     r_busy;
    logic                     r_done;
    logic [1:0]               r_k;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [VAL_W-1:0]  w_op_a;
    logic signed [VAL_W-1:0]  w_op_b;

    always_comb begin
        case (r_k)
            K_X: begin
                w_op_a = i_plane.nx;
                w_op_b = i_px;
            end
            K_Y: begin
                w_op_a = i_plane.ny;
                w_op_b = i_py;
            end
            K_Z: begin
                w_op_a = i_plane.nz;
                w_op_b = i_pz;
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= K_X;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_k    <= K_X;
        end else if (r_busy) begin
            r_k <= r_k + 2'd1;
            if (r_k == K_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // The product of one step is added in the following step.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= -(ACC_W'(i_plane.offset) <<< DIST_SHIFT);
        end else if (r_busy) begin
            if (r_k != K_X) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            if (r_k != K_LAST) begin
                r_prod <= w_op_a * w_op_b;
            end
        end
    end

    assign o_status.done  = r_done;
    assign o_status.front = ~r_acc[ACC_W-1];

endmodule

`default_nettype wire

>>> src/bsp_point_contents_unit.sv
// Top level of the BSP point contents unit: tables, walk sequencer and result register.
//
// Input channel: one word per accepted item (i_in_valid high, o_in_stall low at a
// rising edge). Command 0, 1 and 2 write one node, plane or leaf entry in the cycle
// of acceptance and give no result; a write whose index is beyond its table is
// dropped. Command 3 gives a point and starts a walk from node 0.
// The block is stalled while a walk runs and takes one query at a time; writes
// never stall when the block is idle.
// Each node passes through node read, plane read, start, four multiply-accumulate
// steps of the shared 32x32 multiplier, its done flag and the branch. A node whose
// plane index is beyond the plane table skips the multiplier.
// After the last node's branch the result state loads the output register, and the
// next word is taken only once the sequencer is back in idle after that state.
// If MAX_STEPS nodes pass without a leaf, the result word carries step_limit_hit set
// and zero contents and leaf number.
// Output channel: the result word sits in an output register until taken
// (o_out_valid high, i_out_stall low). While it waits, the block still accepts
// writes and a new query; a finished walk waits for the register to free up.
// Reset clears the sequencer and the output valid flag. Table contents are not
// cleared; an entry read before it was written gives an undefined answer.
`default_nettype none

module bsp_point_contents_unit
    import bspc_pkg::*;
#(
    parameter int NODE_COUNT  = BSPC_NODE_COUNT,
    parameter int PLANE_COUNT = BSPC_PLANE_COUNT,
    parameter int LEAF_COUNT  = BSPC_LEAF_COUNT,
    parameter int MAX_STEPS   = BSPC_MAX_STEPS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [1:0]                i_command,
    input  wire logic [IDX_W-1:0]          i_index,
    input  wire logic signed [VAL_W-1:0]   i_vec_x,
    input  wire logic signed [VAL_W-1:0]   i_vec_y,
    input  wire logic signed [VAL_W-1:0]   i_vec_z,
    input  wire logic signed [VAL_W-1:0]   i_plane_dist,
    input  wire logic [IDX_W-1:0]          i_node_plane,
    input  wire logic signed [CHILD_W-1:0] i_child_front,
    input  wire logic signed [CHILD_W-1:0] i_child_back,
    input  wire logic [VAL_W-1:0]          i_leaf_contents,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [VAL_W-1:0]               o_contents,
    output logic [LEAF_W-1:0]              o_leaf_number,
    output logic                           o_step_limit_hit
);

`include "bsp_point_contents_unit_macros.svh"

    localparam int NAW    = $clog2(NODE_COUNT);
    localparam int PAW    = $clog2(PLANE_COUNT);
    localparam int LAW    = $clog2(LEAF_COUNT);
    localparam int STEP_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_NODE   = 7'b0000010,
        S_PLANE  = 7'b0000100,
        S_DOTGO  = 7'b0001000,
        S_DOT    = 7'b0010000,
        S_STEP   = 7'b0100000,
        S_RESULT = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic w_in_acc;
    logic w_out_acc;
    logic w_slot_free;

    // Walk registers.
    logic signed [VAL_W-1:0]   r_px, r_py, r_pz;
    logic [NODE_W-1:0]         r_node;
    logic                      r_node_ok;
    logic signed [CHILD_W-1:0] r_front, r_back;
    logic                      r_plane_ok;
    logic                      r_take_front;
    logic [STEP_W-1:0]         r_step;
    logic [CHILD_W-1:0]        r_leaf;
    logic                      r_leaf_ok;
    logic                      r_limit;

    // Output register.
    logic                      r_out_valid;
    logic [VAL_W-1:0]          r_contents;
    logic [LEAF_W-1:0]         r_leaf_number;
    logic                      r_limit_out;

    // Table ports.
    logic                      w_node_we, w_plane_we, w_leaf_we;
    t_node_entry               w_node_wdata;
    t_plane_entry              w_plane_wdata;
    t_node_entry               w_node_rd;
    t_plane_entry              w_plane_rd;
    logic [VAL_W-1:0]          w_leaf_rd;
    t_node_entry               w_node_eff;
    logic [IDX_W-1:0]          w_plane_addr;
    logic signed [CHILD_W-1:0] w_next;
    logic                      w_next_leaf;
    logic [CHILD_W-1:0]        w_leaf_idx;
    logic                      w_dot_start;
    t_dot_status               w_dot;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_acc   = r_out_valid && !i_out_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // Writes go straight into the tables in the cycle of acceptance.
    assign w_node_we  = w_in_acc && (i_command == CMD_WR_NODE)
                        && (32'(i_index) < NODE_COUNT);
    assign w_plane_we = w_in_acc && (i_command == CMD_WR_PLANE)
                        && (32'(i_index) < PLANE_COUNT);
    assign w_leaf_we  = w_in_acc && (i_command == CMD_WR_LEAF)
                        && (32'(i_index) < LEAF_COUNT);

    assign w_node_wdata  = '{plane: i_node_plane, front: i_child_front, back: i_child_back};
    assign w_plane_wdata = '{nx: i_vec_x, ny: i_vec_y, nz: i_vec_z, offset: i_plane_dist};

    // A node index beyond the table reads as an all-zero node.
    assign w_node_eff   = r_node_ok ? w_node_rd : '0;
    assign w_plane_addr = w_node_eff.plane;

    assign w_next      = r_take_front ? r_front : r_back;
    assign w_next_leaf = w_next[CHILD_W-1] || (w_next == '0);
    assign w_leaf_idx  = CHILD_W'(-w_next);

    assign w_dot_start = (r_state == S_DOTGO) && r_plane_ok;

    bspc_ram #(
        .WIDTH ($bits(t_node_entry)),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_node_we),
        .i_waddr (NAW'(i_index)),
        .i_wdata (w_node_wdata),
        .i_re    (r_state == S_NODE),
        .i_raddr (NAW'(r_node)),
        .o_rdata (w_node_rd)
    );

    bspc_ram #(
        .WIDTH ($bits(t_plane_entry)),
        .DEPTH (PLANE_COUNT)
    ) u_plane_ram (
        .i_clk   (i_clk),
        .i_we    (w_plane_we),
        .i_waddr (PAW'(i_index)),
        .i_wdata (w_plane_wdata),
        .i_re    (r_state == S_PLANE),
        .i_raddr (PAW'(w_plane_addr)),
        .o_rdata (w_plane_rd)
    );

    bspc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (LEAF_COUNT)
    ) u_leaf_ram (
        .i_clk   (i_clk),
        .i_we    (w_leaf_we),
        .i_waddr (LAW'(i_index)),
        .i_wdata (i_leaf_contents),
        .i_re    ((r_state == S_STEP) && w_next_leaf),
        .i_raddr (LAW'(w_leaf_idx)),
        .o_rdata (w_leaf_rd)
    );

    bspc_dot_unit u_dot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_dot_start),
        .i_plane  (w_plane_rd),
        .i_px     (r_px),
        .i_py     (r_py),
        .i_pz     (r_pz),
        .o_status (w_dot)
    );

    // Sequencer: one node per pass through node, plane, dot and step.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_command == CMD_QUERY)) begin
                    n_state = S_NODE;
                end
            end
            S_NODE:  n_state = S_PLANE;
            S_PLANE: n_state = S_DOTGO;
            S_DOTGO: n_state = r_plane_ok ? S_DOT : S_STEP;
            S_DOT: begin
                if (w_dot.done) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (w_next_leaf || (r_step == STEP_W'(MAX_STEPS - 1))) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_NODE;
                end
            end
            S_RESULT: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_step <= '0;
            end else if ((r_state == S_STEP) && !w_next_leaf
                         && (r_step != STEP_W'(MAX_STEPS - 1))) begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    // Walk datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_command == CMD_QUERY)) begin
            r_px    <= i_vec_x;
            r_py    <= i_vec_y;
            r_pz    <= i_vec_z;
            r_node  <= '0;
            r_limit <= 1'b0;
        end
        if (r_state == S_NODE) begin
            r_node_ok <= (32'(r_node) < NODE_COUNT);
        end
        if (r_state == S_PLANE) begin
            r_front    <= w_node_eff.front;
            r_back     <= w_node_eff.back;
            r_plane_ok <= (32'(w_plane_addr) < PLANE_COUNT);
        end
        // A plane beyond its table gives a side value of zero, so the front child.
        if ((r_state == S_DOTGO) && !r_plane_ok) begin
            r_take_front <= 1'b1;
        end
        if ((r_state == S_DOT) && w_dot.done) begin
            r_take_front <= w_dot.front;
        end
        if (r_state == S_STEP) begin
            if (w_next_leaf) begin
                r_leaf    <= w_leaf_idx;
                r_leaf_ok <= (32'(w_leaf_idx) < LEAF_COUNT);
            end else if (r_step == STEP_W'(MAX_STEPS - 1)) begin
                r_limit <= 1'b1;
            end else begin
                r_node <= w_next[NODE_W-1:0];
            end
        end
    end

    // Output register; it frees up in the same cycle the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_RESULT) && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RESULT) && w_slot_free) begin
            r_limit_out <= r_limit;
            if (r_limit) begin
                r_contents    <= '0;
                r_leaf_number <= '0;
            end else begin
                r_contents    <= r_leaf_ok ? w_leaf_rd : '0;
                r_leaf_number <= r_leaf[LEAF_W-1:0];
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_contents       = r_contents;
    assign o_leaf_number    = r_leaf_number;
    assign o_step_limit_hit = r_limit_out;

    // The shared unit only finishes while the sequencer waits for it.
    `BSPC_ASSERT_SAME(a_dot_done_in_wait, i_clk, i_rst_n, w_dot.done, r_state == S_DOT)
    // A walk that gave up reports no leaf.
    `BSPC_ASSERT_SAME(a_limit_zero, i_clk, i_rst_n, o_out_valid && o_step_limit_hit,
                      (o_contents == '0) && (o_leaf_number == '0))
    // A finished walk holds while the output register is still occupied.
    `BSPC_ASSERT_NEXT(a_result_waits, i_clk, i_rst_n,
                      (r_state == S_RESULT) && r_out_valid && i_out_stall,
                      r_state == S_RESULT)
    // The step count never passes the limit.
    `BSPC_ASSERT_SAME(a_step_bound, i_clk, i_rst_n, r_state != S_IDLE,
                      32'(r_step) < MAX_STEPS)

endmodule

`default_nettype wire
